### design/external_interrupt_edge_controller_assert.svh
// ============================================================================
// External interrupt edge controller assertion macros
// Clocked assertion shorthands that share the block clock and reset.
// ============================================================================
`ifndef EXTERNAL_INTERRUPT_EDGE_CONTROLLER_ASSERT_SVH
`define EXTERNAL_INTERRUPT_EDGE_CONTROLLER_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define EIEC_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define EIEC_ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

### design/eiec_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// eiec_pkg
// Types and constants of the external interrupt edge controller.
// ============================================================================
package eiec_pkg;

    localparam int EDGE_LINES     = 23;
    localparam int GPIO_PORTS     = 4;
    localparam int PINS_PER_PORT  = 16;
    localparam int GPIO_BITS      = GPIO_PORTS * PINS_PER_PORT;
    localparam int GPIO_IDX_W     = $clog2(GPIO_BITS);
    localparam int PORT_IDX_W     = $clog2(GPIO_PORTS);
    localparam int PIN_IDX_W      = $clog2(PINS_PER_PORT);
    localparam int GPIO_LINES     = 16;
    localparam int INTERNAL_FIRST = 16;
    localparam int INTERNAL_COUNT = 7;
    localparam int SEL_W          = 4;
    localparam int SEL_PER_WORD   = 4;
    localparam int SEL_WORDS      = GPIO_LINES / SEL_PER_WORD;
    localparam int SEL_WORD_W     = SEL_W * SEL_PER_WORD;

    // Lines that are able to latch a pending bit.
    localparam logic [EDGE_LINES-1:0] PEND_CAPABLE = 23'h7B_FFFF;

    // Line groups of the combined requests.
    localparam logic [EDGE_LINES-1:0] GROUP0_LINES = 23'h00_0003;
    localparam logic [EDGE_LINES-1:0] GROUP1_LINES = 23'h00_000C;
    localparam logic [EDGE_LINES-1:0] GROUP2_LINES = 23'h00_FFF0;

    // Request types.
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    // Register indexes.
    localparam logic [2:0] REG_MASK = 3'd0;
    localparam logic [2:0] REG_RISE = 3'd1;
    localparam logic [2:0] REG_FALL = 3'd2;
    localparam logic [2:0] REG_PEND = 3'd3;

    typedef struct packed {
        logic [1:0]                req_type;
        logic [2:0]                reg_index;
        logic [31:0]               write_data;
        logic [GPIO_BITS-1:0]      gpio_levels;
        logic [INTERNAL_COUNT-1:0] internal_levels;
    } t_in_item;

    typedef struct packed {
        logic [31:0]           read_data;
        logic [EDGE_LINES-1:0] irq_request;
        logic [2:0]            irq_group;
    } t_out_item;

endpackage

### design/external_interrupt_edge_controller.sv
// Latency: a result beat is valid the cycle after its request beat is accepted.
// Throughput: one request per cycle; the single result register is reloaded
// in the same cycle that its beat is taken, so only output stall slows intake.
// Reset: synchronous, active low; all state registers and port selects clear to zero,
// every line masked, and no result beat is pending; the result data register is not reset.
// ============================================================================
// external_interrupt_edge_controller
// Edge detecting interrupt line controller with bus register access.
// ============================================================================
`timescale 1ns / 1ps
`include "external_interrupt_edge_controller_assert.svh"

module external_interrupt_edge_controller
    import eiec_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    logic [31:0]                         r_mask,  n_mask;
    logic [EDGE_LINES-1:0]               r_rise,  n_rise;
    logic [EDGE_LINES-1:0]               r_fall,  n_fall;
    logic [EDGE_LINES-1:0]               r_pend,  n_pend;
    logic [EDGE_LINES-1:0]               r_prev,  n_prev;
    logic [SEL_WORDS-1:0][SEL_WORD_W-1:0] r_sel,  n_sel;
    logic                                r_out_valid;
    t_out_item                           r_out,   n_out;

    logic [EDGE_LINES-1:0] w_levels;
    logic [EDGE_LINES-1:0] w_irq;
    logic                  w_in_accept;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_in_accept = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Each GPIO line picks its pin from the selected port; out-of-range ports read low.
    always_comb begin
        logic [SEL_W-1:0]      sel;
        logic [GPIO_IDX_W-1:0] pos;
        w_levels = '0;
        for (int i = 0; i < GPIO_LINES; i++) begin
            sel = r_sel[i / SEL_PER_WORD][(i % SEL_PER_WORD) * SEL_W +: SEL_W];
            pos = {sel[PORT_IDX_W-1:0], i[PIN_IDX_W-1:0]};
            if (sel < SEL_W'(GPIO_PORTS)) begin
                w_levels[i] = i_in_data.gpio_levels[pos];
            end
        end
        w_levels[INTERNAL_FIRST +: INTERNAL_COUNT] = i_in_data.internal_levels;
    end

    always_comb begin
        n_mask = r_mask;
        n_rise = r_rise;
        n_fall = r_fall;
        n_pend = r_pend;
        n_prev = r_prev;
        n_sel  = r_sel;
        n_out.read_data = '0;
        case (i_in_data.req_type)
            REQ_TICK: begin
                n_pend = r_pend | (((w_levels & ~r_prev & r_rise)
                                  | (~w_levels & r_prev & r_fall)) & PEND_CAPABLE);
                n_prev = w_levels;
            end
            REQ_WRITE: begin
                case (i_in_data.reg_index)
                    REG_MASK: n_mask = i_in_data.write_data;
                    REG_RISE: n_rise = i_in_data.write_data[EDGE_LINES-1:0];
                    REG_FALL: n_fall = i_in_data.write_data[EDGE_LINES-1:0];
                    REG_PEND: n_pend = r_pend & ~i_in_data.write_data[EDGE_LINES-1:0];
                    default: begin
                        n_sel[i_in_data.reg_index[1:0]] =
                            i_in_data.write_data[SEL_WORD_W-1:0];
                    end
                endcase
            end
            REQ_READ: begin
                case (i_in_data.reg_index)
                    REG_MASK: n_out.read_data = r_mask;
                    REG_RISE: n_out.read_data = 32'(r_rise);
                    REG_FALL: n_out.read_data = 32'(r_fall);
                    REG_PEND: n_out.read_data = 32'(r_pend);
                    default:  n_out.read_data = 32'(r_sel[i_in_data.reg_index[1:0]]);
                endcase
            end
            default: begin
            end
        endcase
        w_irq = n_pend & n_mask[EDGE_LINES-1:0];
        n_out.irq_request  = w_irq;
        n_out.irq_group[0] = |(w_irq & GROUP0_LINES);
        n_out.irq_group[1] = |(w_irq & GROUP1_LINES);
        n_out.irq_group[2] = |(w_irq & GROUP2_LINES);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= '0;
            r_rise      <= '0;
            r_fall      <= '0;
            r_pend      <= '0;
            r_prev      <= '0;
            r_sel       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_accept) begin
                r_mask <= n_mask;
                r_rise <= n_rise;
                r_fall <= n_fall;
                r_pend <= n_pend;
                r_prev <= n_prev;
                r_sel  <= n_sel;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_out <= n_out;
        end
    end

    // The held result always reflects the state that its beat left behind.
    `EIEC_ASSERT_ALWAYS(a_irq_matches_state,
        !r_out_valid || (r_out.irq_request == (r_pend & r_mask[EDGE_LINES-1:0])),
        "request vector disagrees with pending and mask state")
    `EIEC_ASSERT_ALWAYS(a_pend_capable_only, (r_pend & ~PEND_CAPABLE) == '0,
        "pending bit set on a line that cannot pend")
    `EIEC_ASSERT_NEXT(a_pend_clear,
        w_in_accept && (i_in_data.req_type == REQ_WRITE) && (i_in_data.reg_index == REG_PEND),
        (r_pend & $past(i_in_data.write_data[EDGE_LINES-1:0])) == '0,
        "pending bits written with one were not cleared")
    `EIEC_ASSERT_NEXT(a_prev_only_on_tick,
        !(w_in_accept && (i_in_data.req_type == REQ_TICK)), $stable(r_prev),
        "previous levels changed without a tick")

endmodule

### tb/sv/external_interrupt_edge_controller_test.sv
`timescale 1ns / 1ps
// ============================================================================
// external_interrupt_edge_controller_test
// Drives register accesses and level ticks into the interrupt edge controller
// with random gaps and output stalls, and checks every result beat against an
// in-bench model of the registers, edge detection and grouped requests.
// ============================================================================
module external_interrupt_edge_controller_test;
    import eiec_pkg::*;

    localparam logic [1:0] REQ_NONE   = 2'd3;
    localparam logic [2:0] REG_SEL0   = 3'd4;
    localparam logic [2:0] REG_SEL1   = 3'd5;
    localparam logic [2:0] REG_SEL3   = 3'd7;
    localparam int         STALL_LIMIT = 1000;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_data;

    // Model of the controller registers.
    logic [31:0]           mdl_mask;
    logic [EDGE_LINES-1:0] mdl_rise;
    logic [EDGE_LINES-1:0] mdl_fall;
    logic [EDGE_LINES-1:0] mdl_pend;
    logic [EDGE_LINES-1:0] mdl_prev;
    logic [SEL_W-1:0]      mdl_sel [GPIO_LINES];

    t_out_item irq_result_q[$];
    int        error_count = 0;
    int        idle_cycles = 0;
    int        stall_left  = 0;
    bit        calm        = 1'b0;

    external_interrupt_edge_controller dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    always #1 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        if (calm) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 24);
    endfunction

    function automatic void clear_model();
        mdl_mask = '0;
        mdl_rise = '0;
        mdl_fall = '0;
        mdl_pend = '0;
        mdl_prev = '0;
        foreach (mdl_sel[i]) begin
            mdl_sel[i] = '0;
        end
    endfunction

    // Applies one request beat to the model and returns the result it yields.
    function automatic t_out_item predict_irq_result(t_in_item it);
        logic [EDGE_LINES-1:0] now_lv;
        logic [EDGE_LINES-1:0] hits;
        logic [EDGE_LINES-1:0] irq;
        logic [31:0]           rd;
        int                    base;
        t_out_item             r;
        now_lv = '0;
        rd     = '0;
        base   = 4 * (int'(it.reg_index) - int'(REG_SEL0));
        case (it.req_type)
            REQ_TICK: begin
                // A select nibble beyond the last port reads as a low level.
                for (int i = 0; i < GPIO_LINES; i++) begin
                    if (mdl_sel[i] < GPIO_PORTS) begin
                        now_lv[i] = it.gpio_levels[int'(mdl_sel[i]) * PINS_PER_PORT + i];
                    end
                end
                for (int i = 0; i < INTERNAL_COUNT; i++) begin
                    now_lv[INTERNAL_FIRST + i] = it.internal_levels[i];
                end
                hits = (now_lv & ~mdl_prev & mdl_rise) | (~now_lv & mdl_prev & mdl_fall);
                mdl_pend = mdl_pend | (hits & PEND_CAPABLE);
                mdl_prev = now_lv;
            end
            REQ_WRITE: begin
                case (it.reg_index)
                    REG_MASK: mdl_mask = it.write_data;
                    REG_RISE: mdl_rise = it.write_data[EDGE_LINES-1:0];
                    REG_FALL: mdl_fall = it.write_data[EDGE_LINES-1:0];
                    REG_PEND: mdl_pend = mdl_pend & ~it.write_data[EDGE_LINES-1:0];
                    default: begin
                        for (int j = 0; j < SEL_PER_WORD; j++) begin
                            mdl_sel[base + j] = it.write_data[SEL_W*j +: SEL_W];
                        end
                    end
                endcase
            end
            REQ_READ: begin
                case (it.reg_index)
                    REG_MASK: rd = mdl_mask;
                    REG_RISE: rd = 32'(mdl_rise);
                    REG_FALL: rd = 32'(mdl_fall);
                    REG_PEND: rd = 32'(mdl_pend);
                    default: begin
                        for (int j = 0; j < SEL_PER_WORD; j++) begin
                            rd[SEL_W*j +: SEL_W] = mdl_sel[base + j];
                        end
                    end
                endcase
            end
            default: ;
        endcase
        irq           = mdl_pend & mdl_mask[EDGE_LINES-1:0];
        r.read_data   = rd;
        r.irq_request = irq;
        r.irq_group   = {|(irq & GROUP2_LINES), |(irq & GROUP1_LINES), |(irq & GROUP0_LINES)};
        return r;
    endfunction

    function automatic t_in_item make_req(logic [1:0] kind, logic [2:0] idx, logic [31:0] data,
                                          logic [GPIO_BITS-1:0] gpio,
                                          logic [INTERNAL_COUNT-1:0] internal);
        t_in_item it;
        it.req_type        = kind;
        it.reg_index       = idx;
        it.write_data      = data;
        it.gpio_levels     = gpio;
        it.internal_levels = internal;
        return it;
    endfunction

    // Sends one request beat; valid stays high on return so that a following
    // beat with no gap keeps the channel busy.
    task automatic send_request(t_in_item it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic report_mismatch(string field, logic [31:0] want, logic [31:0] got);
        error_count++;
        $display("%0t: %s mismatch, expected %h, actual %h", $realtime, field, want, got);
    endtask

    // Output ready: high, then low for a random stretch that may be empty; held high while calm.
    always @(posedge i_clk) begin
        if (stall_left > 0 && !calm) begin
            i_out_ready <= 1'b0;
            stall_left  <= stall_left - 1;
        end else begin
            i_out_ready <= 1'b1;
            stall_left  <= pick_gap();
        end
    end

    // Result checking and stall watchdog.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                irq_result_q.push_back(predict_irq_result(i_in_data));
            end
            if (o_out_valid && i_out_ready) begin
                if (irq_result_q.size() == 0) begin
                    error_count++;
                    $display("%0t: result beat with nothing outstanding, actual %h",
                             $realtime, o_out_data);
                end else begin
                    want = irq_result_q.pop_front();
                    if (o_out_data.read_data !== want.read_data) begin
                        report_mismatch("read_data", want.read_data, o_out_data.read_data);
                    end
                    if (o_out_data.irq_request !== want.irq_request) begin
                        report_mismatch("irq_request", 32'(want.irq_request),
                                        32'(o_out_data.irq_request));
                    end
                    if (o_out_data.irq_group !== want.irq_group) begin
                        report_mismatch("irq_group", 32'(want.irq_group),
                                        32'(o_out_data.irq_group));
                    end
                end
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no beat moved for %0d cycles", $realtime, idle_cycles);
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic test_register_access();
        send_request(make_req(REQ_WRITE, REG_MASK, 32'hFFFF_FFFF, '0, '0));
        send_request(make_req(REQ_READ,  REG_MASK, '0, '0, '0));
        send_request(make_req(REQ_WRITE, REG_RISE, 32'hFFFF_FFFF, '0, '0));
        send_request(make_req(REQ_READ,  REG_RISE, '0, '0, '0));
        send_request(make_req(REQ_WRITE, REG_FALL, 32'hFFFF_FFFF, '0, '0));
        send_request(make_req(REQ_READ,  REG_FALL, '0, '0, '0));
        // Upper half of a select word is dropped; lines 0-3 now point past port D.
        send_request(make_req(REQ_WRITE, REG_SEL0, 32'hFFFF_FFFF, '0, '0));
        send_request(make_req(REQ_READ,  REG_SEL0, '0, '0, '0));
        // An unknown request type leaves every register alone.
        send_request(make_req(REQ_NONE,  REG_MASK, 32'h0, '1, '1));
        send_request(make_req(REQ_READ,  REG_PEND, '0, '0, '0));
    endtask

    task automatic test_edge_detect();
        send_request(make_req(REQ_WRITE, REG_SEL1, 32'hABCD_3210, '0, '0));
        send_request(make_req(REQ_WRITE, REG_SEL3, 32'h0000_0213, '0, '0));
        // Every line rises but 0-3, whose selects point past port D; line 18 must stay clear of the pending register.
        send_request(make_req(REQ_TICK,  REG_MASK, '0, '1, '1));
        send_request(make_req(REQ_READ,  REG_PEND, '0, '0, '0));
        send_request(make_req(REQ_WRITE, REG_PEND, 32'hFFFF_FFFF, '0, '0));
        send_request(make_req(REQ_TICK,  REG_MASK, '0, '0, '0));
        send_request(make_req(REQ_READ,  REG_PEND, '0, '0, '0));
        send_request(make_req(REQ_WRITE, REG_MASK, 32'h0, '0, '0));
        send_request(make_req(REQ_TICK,  REG_MASK, '0, '1, '1));
        send_request(make_req(REQ_WRITE, REG_MASK, 32'h0000_000C, '0, '0));
        send_request(make_req(REQ_WRITE, REG_PEND, 32'h0000_0005, '0, '0));
        send_request(make_req(REQ_READ,  REG_PEND, '0, '0, '0));
        send_request(make_req(REQ_WRITE, REG_PEND, 32'hFFFF_FFFF, '0, '0));
    endtask

    function automatic t_in_item random_request();
        t_in_item it;
        int       r;
        it.gpio_levels     = {$urandom, $urandom};
        it.internal_levels = INTERNAL_COUNT'($urandom);
        it.write_data      = $urandom;
        it.reg_index       = 3'($urandom_range(0, 7));
        r = $urandom_range(0, 99);
        if (r < 55) begin
            it.req_type = REQ_TICK;
            if ($urandom_range(0, 19) == 0) begin
                it.gpio_levels     = {GPIO_BITS{it.write_data[0]}};
                it.internal_levels = {INTERNAL_COUNT{it.write_data[0]}};
            end
        end else if (r < 78) begin
            it.req_type = REQ_WRITE;
            if (it.reg_index >= REG_SEL0) begin
                // Mostly real ports, now and then a select past the last one.
                for (int j = 0; j < SEL_PER_WORD; j++) begin
                    it.write_data[SEL_W*j +: SEL_W] = ($urandom_range(0, 7) == 0) ?
                        SEL_W'($urandom_range(GPIO_PORTS, 15)) :
                        SEL_W'($urandom_range(0, GPIO_PORTS - 1));
                end
            end else if (it.reg_index == REG_PEND) begin
                it.write_data = $urandom & $urandom;
            end else if ($urandom_range(0, 7) == 0) begin
                it.write_data = '1;
            end
        end else if (r < 97) begin
            it.req_type = REQ_READ;
        end else begin
            it.req_type = REQ_NONE;
        end
        return it;
    endfunction

    task automatic test_random_traffic(int count, bit no_idle);
        calm = no_idle;
        repeat (count) send_request(random_request());
        calm = 1'b0;
    endtask

    initial begin
        clear_model();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_register_access();
        test_edge_detect();
        test_random_traffic(600, 1'b0);
        test_random_traffic(300, 1'b1);
        test_random_traffic(750, 1'b0);
        i_in_valid <= 1'b0;
        // The last beat is queued by the checker at the edge just passed.
        @(posedge i_clk);
        while (irq_result_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
